FILE: rtl/core/pdtas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pdtas_pkg;

  // Field codes that mean "unset".
  localparam logic [4:0] YEAR_UNSET   = 5'h1F;
  localparam logic [3:0] MONTH_UNSET  = 4'hF;
  localparam logic [5:0] DAY_UNSET    = 6'h3F;
  localparam logic [4:0] HOUR_UNSET   = 5'h1F;
  localparam logic [5:0] MINUTE_UNSET = 6'h3F;

  // Days from 1970-01-01 to 2000-01-01.
  localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
  // Bias in seconds, a whole number of days, that keeps the shifted time count non-negative.
  localparam logic [34:0] BIAS_SECS    = 35'd2147558400;
  // Days from 0000-03-01 to the biased day zero (719468 minus the bias).
  localparam logic [19:0] EPOCH_SHIFT  = 20'd694612;
  // Offset that turns a biased day count into a Sunday-based weekday.
  localparam logic [19:0] WDAY_SHIFT   = 20'd5;
  localparam logic [19:0] ERA_DAYS     = 20'd146097;

  // Reciprocals for exact division by small constants on 20-bit values.
  localparam logic [31:0] M_DIV7    = 32'((64'd1 << 32) / 7);
  localparam logic [31:0] M_DIV60   = 32'((64'd1 << 32) / 60);
  localparam logic [31:0] M_DIV100  = 32'((64'd1 << 32) / 100);
  localparam logic [31:0] M_DIV153  = 32'((64'd1 << 32) / 153);
  localparam logic [31:0] M_DIV365  = 32'((64'd1 << 32) / 365);
  localparam logic [31:0] M_DIV1460 = 32'((64'd1 << 32) / 1460);
  // x / 675 for x below 2**26, taken as (x * M) >> 36.
  localparam logic [26:0] M_DIV675  = 27'((64'd1 << 36) / 675);

  // Quotient x / d, with m the floor of 2**32 / d. The estimate is low by
  // at most one, and a single remainder check fixes it.
  function automatic logic [19:0] cdiv(input logic [19:0] x, input logic [19:0] d,
                                       input logic [31:0] m);
    logic [51:0] p;
    logic [19:0] q;
    logic [39:0] qd;
    logic [20:0] r;
    p  = 52'(x) * 52'(m);
    q  = p[51:32];
    qd = 40'(q) * 40'(d);
    r  = 21'(x) - qd[20:0];
    if (r >= 21'(d)) begin
      q = q + 20'd1;
    end
    return q;
  endfunction

  // Days before the first of a zero-based month in a common year.
  function automatic logic [8:0] month_start(input logic [3:0] m0);
    logic [8:0] v;
    case (m0)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      default: v = 9'd334;
    endcase
    return v;
  endfunction

  // Days before each month of a March-based year.
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      default: v = 9'd337;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/packed_date_time_add_seconds_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                        Dir  Notes
// in        in_valid in_ready in_time_word in_delta_seconds  in   date word and signed offset
// out       out_valid out_ready out_result_word          out  moved date word
//
// Ten register stages; an item enters every cycle while the output side keeps
// up. The depth is set by the chain of constant divisions (seconds to days,
// days to civil date). rst_n clears only the stage valid bits. A stall at the
// output holds the last stage, and earlier stages keep filling any empty slot
// behind it.
module packed_date_time_add_seconds_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire        [31:0] in_time_word,
  input  wire signed [31:0] in_delta_seconds,
  output logic              out_valid,
  input  wire               out_ready,
  output logic       [31:0] out_result_word
);

  logic [10:1] v_r;
  logic [10:1] en;

  always_comb begin
    en[10] = !v_r[10] || out_ready;
    for (int k = 9; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[10];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= 10; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: base day count and seconds of day
  logic [4:0]  yf;
  logic [3:0]  mf;
  logic [5:0]  df;
  logic [4:0]  hf;
  logic [5:0]  nf;
  logic [4:0]  yo;
  logic [3:0]  m0;
  logic        leap;
  logic [15:0] days1_nxt;
  logic [16:0] sod1_nxt;
  logic [15:0] days1_r;
  logic [16:0] sod1_r;
  logic signed [31:0] delta1_r;
  logic [1:0]  flags1_r;

  always_comb begin
    yf = in_time_word[28:24];
    mf = in_time_word[23:20];
    df = in_time_word[19:14];
    hf = in_time_word[10:6];
    nf = in_time_word[5:0];
    if (mf >= 4'd12) begin
      yo = yf + 5'd1;
      m0 = mf - 4'd12;
    end else begin
      yo = yf;
      m0 = mf;
    end
    leap = (yo[1:0] == 2'd0);
    days1_nxt = pdtas_pkg::DAYS_TO_2000 + 16'(yo) * 16'd365 + 16'((6'(yo) + 6'd3) >> 2)
              + 16'(pdtas_pkg::month_start(m0)) + 16'(leap && m0 >= 4'd2) + 16'(df);
    sod1_nxt = '0;
    if (hf != pdtas_pkg::HOUR_UNSET) begin
      sod1_nxt = 17'(hf) * 17'd3600;
      if (nf != pdtas_pkg::MINUTE_UNSET) begin
        sod1_nxt = sod1_nxt + 17'(nf) * 17'd60;
      end
    end
    if (yf == pdtas_pkg::YEAR_UNSET || mf == pdtas_pkg::MONTH_UNSET ||
        df == pdtas_pkg::DAY_UNSET) begin
      days1_nxt = '0;
      sod1_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days1_r  <= days1_nxt;
      sod1_r   <= sod1_nxt;
      delta1_r <= in_delta_seconds;
      flags1_r <= in_time_word[30:29];
    end
  end

  // ---------------- stage 2: biased second count
  logic [34:0] u2_nxt;
  logic [32:0] u2_r;
  logic [1:0]  flags2_r;

  assign u2_nxt = 35'(days1_r) * 35'd86400 + 35'(sod1_r) + 35'(delta1_r)
                + pdtas_pkg::BIAS_SECS;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      u2_r     <= u2_nxt[32:0];
      flags2_r <= flags1_r;
    end
  end

  // ---------------- stage 3: day estimate (86400 = 128 * 675)
  logic [52:0] p3;
  logic [16:0] q3_r;
  logic [25:0] x3_r;
  logic [6:0]  lo3_r;
  logic [1:0]  flags3_r;

  assign p3 = 53'(u2_r[32:7]) * 53'(pdtas_pkg::M_DIV675);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      q3_r     <= p3[52:36];
      x3_r     <= u2_r[32:7];
      lo3_r    <= u2_r[6:0];
      flags3_r <= flags2_r;
    end
  end

  // ---------------- stage 4: exact day and second of day
  logic [26:0] r4;
  logic [16:0] q4_nxt;
  logic [9:0]  r4_fix;
  logic [16:0] q4_r;
  logic [16:0] sod4_r;
  logic [1:0]  flags4_r;

  always_comb begin
    r4 = 27'(x3_r) - 27'(q3_r) * 27'd675;
    if (r4 >= 27'd675) begin
      q4_nxt = q3_r + 17'd1;
      r4_fix = 10'(r4 - 27'd675);
    end else begin
      q4_nxt = q3_r;
      r4_fix = r4[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      q4_r     <= q4_nxt;
      sod4_r   <= {r4_fix, lo3_r};
      flags4_r <= flags3_r;
    end
  end

  // ---------------- stage 5: era, day of era, minutes, weekday
  logic [19:0] zz5;
  logic [2:0]  era5_nxt;
  logic [19:0] doe5_full;
  logic [19:0] mt5;
  logic [19:0] wx5;
  logic [19:0] wq5;
  logic [19:0] wr5;
  logic [2:0]  era5_r;
  logic [17:0] doe5_r;
  logic [10:0] mt5_r;
  logic [2:0]  wd5_r;
  logic [1:0]  flags5_r;

  always_comb begin
    zz5 = 20'(q4_r) + pdtas_pkg::EPOCH_SHIFT;
    era5_nxt = 3'(zz5 >= pdtas_pkg::ERA_DAYS) + 3'(zz5 >= 20'd292194)
             + 3'(zz5 >= 20'd438291) + 3'(zz5 >= 20'd584388) + 3'(zz5 >= 20'd730485);
    doe5_full = zz5 - 20'(era5_nxt) * pdtas_pkg::ERA_DAYS;
    mt5 = pdtas_pkg::cdiv(20'(sod4_r), 20'd60, pdtas_pkg::M_DIV60);
    wx5 = 20'(q4_r) + pdtas_pkg::WDAY_SHIFT;
    wq5 = pdtas_pkg::cdiv(wx5, 20'd7, pdtas_pkg::M_DIV7);
    wr5 = wx5 - 20'(wq5 * 20'd7);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      era5_r   <= era5_nxt;
      doe5_r   <= doe5_full[17:0];
      mt5_r    <= mt5[10:0];
      wd5_r    <= wr5[2:0];
      flags5_r <= flags4_r;
    end
  end

  // ---------------- stage 6: year-of-era numerator, hour and minute
  logic [19:0] c1460;
  logic [2:0]  c36524;
  logic [17:0] yn6_nxt;
  logic [19:0] hr6;
  logic [10:0] mn6;
  logic [17:0] yn6_r;
  logic [2:0]  era6_r;
  logic [17:0] doe6_r;
  logic [4:0]  hr6_r;
  logic [5:0]  mn6_r;
  logic [2:0]  wd6_r;
  logic [1:0]  flags6_r;

  always_comb begin
    c1460  = pdtas_pkg::cdiv(20'(doe5_r), 20'd1460, pdtas_pkg::M_DIV1460);
    c36524 = 3'(doe5_r >= 18'd36524) + 3'(doe5_r >= 18'd73048)
           + 3'(doe5_r >= 18'd109572) + 3'(doe5_r >= 18'd146096);
    yn6_nxt = doe5_r - 18'(c1460) + 18'(c36524) - 18'(doe5_r == 18'd146096);
    hr6 = pdtas_pkg::cdiv(20'(mt5_r), 20'd60, pdtas_pkg::M_DIV60);
    mn6 = mt5_r - 11'(hr6 * 20'd60);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      yn6_r    <= yn6_nxt;
      era6_r   <= era5_r;
      doe6_r   <= doe5_r;
      hr6_r    <= hr6[4:0];
      mn6_r    <= mn6[5:0];
      wd6_r    <= wd5_r;
      flags6_r <= flags5_r;
    end
  end

  // ---------------- stage 7: year of era
  logic [19:0] yoe7;
  logic [8:0]  yoe7_r;
  logic [2:0]  era7_r;
  logic [17:0] doe7_r;
  logic [4:0]  hr7_r;
  logic [5:0]  mn7_r;
  logic [2:0]  wd7_r;
  logic [1:0]  flags7_r;

  assign yoe7 = pdtas_pkg::cdiv(20'(yn6_r), 20'd365, pdtas_pkg::M_DIV365);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      yoe7_r   <= yoe7[8:0];
      era7_r   <= era6_r;
      doe7_r   <= doe6_r;
      hr7_r    <= hr6_r;
      mn7_r    <= mn6_r;
      wd7_r    <= wd6_r;
      flags7_r <= flags6_r;
    end
  end

  // ---------------- stage 8: day of year (March based)
  logic [19:0] c100;
  logic [17:0] ys8;
  logic [17:0] doy8;
  logic [8:0]  doy8_r;
  logic [8:0]  yoe8_r;
  logic [2:0]  era8_r;
  logic [4:0]  hr8_r;
  logic [5:0]  mn8_r;
  logic [2:0]  wd8_r;
  logic [1:0]  flags8_r;

  always_comb begin
    c100 = pdtas_pkg::cdiv(20'(yoe7_r), 20'd100, pdtas_pkg::M_DIV100);
    ys8  = 18'(yoe7_r) * 18'd365 + 18'(yoe7_r >> 2) - 18'(c100);
    doy8 = doe7_r - ys8;
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      doy8_r   <= doy8[8:0];
      yoe8_r   <= yoe7_r;
      era8_r   <= era7_r;
      hr8_r    <= hr7_r;
      mn8_r    <= mn7_r;
      wd8_r    <= wd7_r;
      flags8_r <= flags7_r;
    end
  end

  // ---------------- stage 9: March-based month
  logic [19:0] mp9;
  logic [3:0]  mp9_r;
  logic [8:0]  doy9_r;
  logic [8:0]  yoe9_r;
  logic [2:0]  era9_r;
  logic [4:0]  hr9_r;
  logic [5:0]  mn9_r;
  logic [2:0]  wd9_r;
  logic [1:0]  flags9_r;

  assign mp9 = pdtas_pkg::cdiv(20'(doy8_r) * 20'd5 + 20'd2, 20'd153, pdtas_pkg::M_DIV153);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      mp9_r    <= mp9[3:0];
      doy9_r   <= doy8_r;
      yoe9_r   <= yoe8_r;
      era9_r   <= era8_r;
      hr9_r    <= hr8_r;
      mn9_r    <= mn8_r;
      wd9_r    <= wd8_r;
      flags9_r <= flags8_r;
    end
  end

  // ---------------- stage 10: civil date and packing
  logic [8:0]  dd10;
  logic [3:0]  mon10;
  logic [11:0] yr10;
  logic signed [12:0] yv10;
  logic [31:0] res10_nxt;
  logic [31:0] res10_r;

  always_comb begin
    dd10 = doy9_r - pdtas_pkg::mar_start(mp9_r);
    // Zero-based month: March-based month 0 is March.
    mon10 = (mp9_r < 4'd10) ? mp9_r + 4'd2 : mp9_r - 4'd10;
    yr10 = 12'(yoe9_r) + 12'(era9_r) * 12'd400 + 12'(mp9_r >= 4'd10);
    yv10 = $signed({1'b0, yr10}) - 13'sd2000;
    if (yv10 >= 13'sd100) begin
      yv10 = yv10 - 13'sd100;
    end
    res10_nxt = {1'b0, flags9_r, yv10[4:0], mon10, dd10[5:0], wd9_r, hr9_r, mn9_r};
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      res10_r <= res10_nxt;
    end
  end

  assign out_result_word = res10_r;

`ifndef SYNTHESIS
  a_wday_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_word[13:11] != 3'd7)
    else $error("weekday out of range");
  a_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_word[23:20] < 4'd12)
    else $error("month out of range");
  a_time_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_word[10:6] < 5'd24 && out_result_word[5:0] < 6'd60))
    else $error("hour or minute out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[10] && !out_ready) |-> !en[10])
    else $error("last stage not held during stall");
`endif

endmodule
`default_nettype wire
